FILE: src/scacc_pkg.sv
// scacc_pkg: shared types and constants for the sparse complex accumulator.
// Used by every module under src; depends on nothing.
package scacc_pkg;

   // fixed field widths of the request and response beats
   localparam int OP_W       = 3;
   localparam int OCC_W      = 16;
   localparam int COEF_W     = 32;
   localparam int CNT_OUT_W  = 7;

   // defaults for the top level parameters
   localparam int CAPACITY_DEF  = 64;
   localparam int SITES_DEF     = 16;
   localparam int FRAC_BITS_DEF = 16;

   // operation codes; unused codes are decoded as a query
   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_SCALE = 3'd2,
      OP_QUERY = 3'd3,
      OP_ERASE = 3'd4
   } op_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DISPATCH,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_APPEND,
      ST_SC_RD,
      ST_SC_START,
      ST_SC_WAIT,
      ST_ER_RD,
      ST_ER_WR,
      ST_FIN_RD,
      ST_FIN
   } ctl_state_type;

   // write strobes from the controller to the term store
   typedef struct packed {
      logic key_we;
      logic coef_we;
   } mem_wr_type;

endpackage

FILE: src/scacc_store.sv
// scacc_store: key memory and coefficient memory of the term table.
// One write and one registered read per cycle each; uses scacc_pkg.
module scacc_store #(
   parameter int CAPACITY = scacc_pkg::CAPACITY_DEF,
   parameter int KEY_W    = scacc_pkg::OCC_W,
   localparam int AW      = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic [AW-1:0]                 rd_addr,
   input  logic [AW-1:0]                 wr_addr,
   input  scacc_pkg::mem_wr_type         mem_wr,
   input  logic [KEY_W-1:0]              wr_key,
   input  logic [2*scacc_pkg::COEF_W-1:0] wr_coef,
   output logic [KEY_W-1:0]              rd_key,
   output logic [2*scacc_pkg::COEF_W-1:0] rd_coef
);
   import scacc_pkg::*;

   logic [KEY_W-1:0]    key_mem_ff  [CAPACITY];
   logic [2*COEF_W-1:0] coef_mem_ff [CAPACITY];
   logic [KEY_W-1:0]    rd_key_ff;
   logic [2*COEF_W-1:0] rd_coef_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_wr.key_we) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      if (mem_wr.coef_we) begin
         coef_mem_ff[wr_addr] <= wr_coef;
      end
   end

   // registered read port, shared address for both arrays
   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem_ff[rd_addr];
      rd_coef_ff <= coef_mem_ff[rd_addr];
   end

   assign rd_key  = rd_key_ff;
   assign rd_coef = rd_coef_ff;

endmodule

FILE: src/scacc_scale.sv
// scacc_scale: complex multiply of one coefficient by the scale factor.
// One shared 32x32 multiplier for the four products, then a registered sum; uses scacc_pkg.
module scacc_scale #(
   parameter int FRAC_BITS = scacc_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [2*scacc_pkg::COEF_W-1:0]  coef_in,
   input  logic signed [scacc_pkg::COEF_W-1:0] fac_re,
   input  logic signed [scacc_pkg::COEF_W-1:0] fac_im,
   output logic                            done,
   output logic signed [scacc_pkg::COEF_W-1:0] out_re,
   output logic signed [scacc_pkg::COEF_W-1:0] out_im
);
   import scacc_pkg::*;

   localparam int PW = 2 * COEF_W;
   localparam int SW = PW + 1;
   localparam logic [2:0] STEP_AC   = 3'd0;
   localparam logic [2:0] STEP_BD   = 3'd1;
   localparam logic [2:0] STEP_AD   = 3'd2;
   localparam logic [2:0] STEP_BC   = 3'd3;
   localparam logic [2:0] STEP_SUM  = 3'd4;
   localparam logic [2:0] STEP_DONE = 3'd5;
   localparam logic signed [SW-1:0] POS_LIM = SW'(2147483647);
   localparam logic signed [SW-1:0] NEG_LIM = -SW'(64'sd2147483648);

   logic                     run_ff;
   logic [2:0]               step_ff;
   logic signed [COEF_W-1:0] a_ff, b_ff;
   logic signed [PW-1:0]     ac_ff, bd_ff, ad_ff, bc_ff;
   logic signed [SW-1:0]     re_sum_ff, im_sum_ff;
   logic signed [COEF_W-1:0] mul_x, mul_y;
   logic signed [PW-1:0]     mul_p;
   logic signed [SW-1:0]     re_sh, im_sh;

   function automatic logic signed [COEF_W-1:0] sat_word(input logic signed [SW-1:0] x);
      logic signed [COEF_W-1:0] r;
      if (x > POS_LIM) begin
         r = POS_LIM[COEF_W-1:0];
      end else if (x < NEG_LIM) begin
         r = NEG_LIM[COEF_W-1:0];
      end else begin
         r = x[COEF_W-1:0];
      end
      return r;
   endfunction

   // sequencing: four products, one sum, one output cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= STEP_AC;
      end else if (start) begin
         run_ff  <= 1'b1;
         step_ff <= STEP_AC;
      end else if (run_ff) begin
         if (step_ff == STEP_DONE) begin
            run_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (step_ff)
         STEP_AC: begin mul_x = a_ff; mul_y = fac_re; end
         STEP_BD: begin mul_x = b_ff; mul_y = fac_im; end
         STEP_AD: begin mul_x = a_ff; mul_y = fac_im; end
         default: begin mul_x = b_ff; mul_y = fac_re; end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= coef_in[COEF_W-1:0];
         b_ff <= coef_in[PW-1:COEF_W];
      end
      if (run_ff) begin
         unique case (step_ff)
            STEP_AC:  ac_ff <= mul_p;
            STEP_BD:  bd_ff <= mul_p;
            STEP_AD:  ad_ff <= mul_p;
            STEP_BC:  bc_ff <= mul_p;
            STEP_SUM: begin
               re_sum_ff <= {ac_ff[PW-1], ac_ff} - {bd_ff[PW-1], bd_ff};
               im_sum_ff <= {ad_ff[PW-1], ad_ff} + {bc_ff[PW-1], bc_ff};
            end
            default: ;
         endcase
      end
   end

   // floor shift back to Q format and saturate
   assign re_sh  = re_sum_ff >>> FRAC_BITS;
   assign im_sh  = im_sum_ff >>> FRAC_BITS;
   assign out_re = sat_word(re_sh);
   assign out_im = sat_word(im_sh);
   assign done   = run_ff && (step_ff == STEP_DONE);

endmodule

FILE: src/scacc_ctrl.sv
// scacc_ctrl: sequencer of the accumulator: key search, accumulate, append,
// scale walk, compaction and result read. Drives scacc_store and scacc_scale; uses scacc_pkg.
module scacc_ctrl #(
   parameter int CAPACITY = scacc_pkg::CAPACITY_DEF,
   parameter int KEY_W    = scacc_pkg::OCC_W,
   localparam int AW      = $clog2(CAPACITY),
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [scacc_pkg::OP_W-1:0]            req_operation,
   input  logic [scacc_pkg::OCC_W-1:0]           req_occupation,
   input  logic signed [scacc_pkg::COEF_W-1:0]   req_coef_re,
   input  logic signed [scacc_pkg::COEF_W-1:0]   req_coef_im,
   output logic                                  rsp_valid,
   output logic signed [scacc_pkg::COEF_W-1:0]   rsp_result_re,
   output logic signed [scacc_pkg::COEF_W-1:0]   rsp_result_im,
   output logic                                  rsp_key_found,
   output logic                                  rsp_table_full,
   output logic [scacc_pkg::CNT_OUT_W-1:0]       rsp_entry_count,
   output logic [AW-1:0]                         rd_addr,
   output logic [AW-1:0]                         wr_addr,
   output scacc_pkg::mem_wr_type                 mem_wr,
   output logic [KEY_W-1:0]                      wr_key,
   output logic [2*scacc_pkg::COEF_W-1:0]        wr_coef,
   input  logic [KEY_W-1:0]                      rd_key,
   input  logic [2*scacc_pkg::COEF_W-1:0]        rd_coef,
   output logic                                  scl_start,
   input  logic                                  scl_done,
   input  logic signed [scacc_pkg::COEF_W-1:0]   scl_re,
   input  logic signed [scacc_pkg::COEF_W-1:0]   scl_im,
   output logic signed [scacc_pkg::COEF_W-1:0]   fac_re,
   output logic signed [scacc_pkg::COEF_W-1:0]   fac_im
);
   import scacc_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic signed [COEF_W-1:0] S_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] S_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   ctl_state_type            state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic signed [COEF_W-1:0] cre_ff, cre_in, cim_ff, cim_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         wrj_ff, wrj_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pidx_ff, pidx_in;
   logic                     found_ff, found_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic                     res_ok_ff, res_ok_in;
   logic [AW-1:0]            res_idx_ff, res_idx_in;
   logic                     full_ff, full_in;
   logic                     issue;
   logic                     is_sub;
   logic signed [COEF_W-1:0] rd_re, rd_im;

   function automatic op_type decode_op(input logic [OP_W-1:0] code);
      op_type r;
      unique case (code)
         OP_ADD:   r = OP_ADD;
         OP_SUB:   r = OP_SUB;
         OP_SCALE: r = OP_SCALE;
         OP_ERASE: r = OP_ERASE;
         default:  r = OP_QUERY;
      endcase
      return r;
   endfunction

   // saturating add or subtract of two coefficient parts
   function automatic logic signed [COEF_W-1:0] sat_add(
      input logic signed [COEF_W-1:0] x,
      input logic signed [COEF_W-1:0] y,
      input logic                     sub
   );
      logic [COEF_W:0]          s;
      logic signed [COEF_W-1:0] r;
      s = sub ? ({x[COEF_W-1], x} - {y[COEF_W-1], y})
              : ({x[COEF_W-1], x} + {y[COEF_W-1], y});
      if (s[COEF_W] != s[COEF_W-1]) begin
         r = s[COEF_W] ? S_MIN : S_MAX;
      end else begin
         r = s[COEF_W-1:0];
      end
      return r;
   endfunction

   assign issue  = scan_ff < count_ff;
   assign is_sub = op_ff == OP_SUB;
   assign rd_re  = rd_coef[COEF_W-1:0];
   assign rd_im  = rd_coef[2*COEF_W-1:COEF_W];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // operation and walk registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      cre_ff     <= cre_in;
      cim_ff     <= cim_in;
      scan_ff    <= scan_in;
      wrj_ff     <= wrj_in;
      pidx_ff    <= pidx_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      res_ok_ff  <= res_ok_in;
      res_idx_ff <= res_idx_in;
      full_ff    <= full_in;
   end

   // next state and memory commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      cre_in     = cre_ff;
      cim_in     = cim_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      wrj_in     = wrj_ff;
      pend_in    = pend_ff;
      pidx_in    = pidx_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      res_ok_in  = res_ok_ff;
      res_idx_in = res_idx_ff;
      full_in    = full_ff;
      rd_addr    = scan_ff[AW-1:0];
      wr_addr    = scan_ff[AW-1:0];
      mem_wr     = '0;
      wr_key     = key_ff;
      wr_coef    = rd_coef;
      scl_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = decode_op(req_operation);
               key_in    = req_occupation[KEY_W-1:0];
               cre_in    = req_coef_re;
               cim_in    = req_coef_im;
               scan_in   = '0;
               pend_in   = 1'b0;
               full_in   = 1'b0;
               res_ok_in = 1'b0;
               state_in  = ST_SEARCH;
            end
         end

         // one key read per cycle, compared in the following cycle
         ST_SEARCH: begin
            pend_in = issue;
            pidx_in = scan_ff[AW-1:0];
            scan_in = issue ? scan_ff + ONE_CNT : scan_ff;
            if (pend_ff && (rd_key == key_ff)) begin
               found_in = 1'b1;
               idx_in   = pidx_ff;
               pend_in  = 1'b0;
               state_in = ST_DISPATCH;
            end else if (!pend_ff && !issue) begin
               found_in = 1'b0;
               idx_in   = '0;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            res_ok_in  = found_ff;
            res_idx_in = idx_ff;
            scan_in    = '0;
            wrj_in     = '0;
            unique case (op_ff)
               OP_ADD, OP_SUB: begin
                  if ((cre_ff == '0) && (cim_ff == '0)) begin
                     state_in = ST_FIN_RD;
                  end else if (found_ff) begin
                     state_in = ST_ACC_RD;
                  end else if (count_ff == CAP_CNT) begin
                     full_in  = 1'b1;
                     state_in = ST_FIN_RD;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end
               OP_SCALE: state_in = ST_SC_RD;
               OP_ERASE: begin
                  res_ok_in = 1'b0;
                  state_in  = ST_ER_RD;
               end
               default: state_in = ST_FIN_RD;
            endcase
         end

         ST_ACC_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_ACC_WR;
         end

         ST_ACC_WR: begin
            wr_addr        = idx_ff;
            mem_wr.coef_we = 1'b1;
            wr_coef        = {sat_add(rd_im, cim_ff, is_sub), sat_add(rd_re, cre_ff, is_sub)};
            state_in       = ST_FIN_RD;
         end

         // new entry at the tail, negated for subtract
         ST_APPEND: begin
            wr_addr        = count_ff[AW-1:0];
            mem_wr.key_we  = 1'b1;
            mem_wr.coef_we = 1'b1;
            wr_coef        = is_sub ? {sat_add('0, cim_ff, 1'b1), sat_add('0, cre_ff, 1'b1)}
                                    : {cim_ff, cre_ff};
            count_in       = count_ff + ONE_CNT;
            res_ok_in      = 1'b1;
            res_idx_in     = count_ff[AW-1:0];
            state_in       = ST_FIN_RD;
         end

         // scale walk: read, multiply, write back
         ST_SC_RD: begin
            state_in = issue ? ST_SC_START : ST_FIN_RD;
         end

         ST_SC_START: begin
            scl_start = 1'b1;
            state_in  = ST_SC_WAIT;
         end

         ST_SC_WAIT: begin
            if (scl_done) begin
               mem_wr.coef_we = 1'b1;
               wr_coef        = {scl_im, scl_re};
               scan_in        = scan_ff + ONE_CNT;
               state_in       = ST_SC_RD;
            end
         end

         // compaction: read entry, copy down when nonzero
         ST_ER_RD: begin
            if (issue) begin
               state_in = ST_ER_WR;
            end else begin
               count_in = wrj_ff;
               state_in = ST_FIN_RD;
            end
         end

         ST_ER_WR: begin
            if (rd_coef != '0) begin
               wr_addr        = wrj_ff[AW-1:0];
               mem_wr.key_we  = 1'b1;
               mem_wr.coef_we = 1'b1;
               wr_key         = rd_key;
               wrj_in         = wrj_ff + ONE_CNT;
               if (found_ff && (scan_ff[AW-1:0] == idx_ff)) begin
                  res_ok_in  = 1'b1;
                  res_idx_in = wrj_ff[AW-1:0];
               end
            end
            scan_in  = scan_ff + ONE_CNT;
            state_in = ST_ER_RD;
         end

         ST_FIN_RD: begin
            rd_addr  = res_idx_ff;
            state_in = ST_FIN;
         end

         ST_FIN: begin
            state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // response beat
   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = state_ff == ST_FIN;
   assign rsp_result_re   = res_ok_ff ? rd_re : '0;
   assign rsp_result_im   = res_ok_ff ? rd_im : '0;
   assign rsp_key_found   = found_ff;
   assign rsp_table_full  = full_ff;
   assign rsp_entry_count = CNT_OUT_W'(count_ff);
   assign fac_re          = cre_ff;
   assign fac_im          = cim_ff;

endmodule

FILE: src/sparse_complex_accumulator_top.sv
// Channel  | Ports                                        | Beat taken when
// ---------+----------------------------------------------+------------------------
// request  | start, busy, req_operation/occupation/coef_* | start && !busy
// response | rsp_valid, rsp_result_*, rsp_key_found, ...  | rsp_valid (one cycle)
//
// Every request first walks the key memory, one entry per cycle. Then a query reads the result,
// an append writes the new entry at the tail, an accumulate reads and writes back the entry;
// scale walks every entry (shared 32x32 multiplier, four products each); erase drops all-zero
// entries, reading each entry in turn and copying the nonzero ones down over the gaps.
// One request at a time; busy is high from acceptance through the response cycle.
// Synchronous reset empties the table (entry count zero); memories are not cleared.
// The receiver cannot stall: the response stands for exactly one cycle.
module sparse_complex_accumulator_top #(
   parameter int CAPACITY  = scacc_pkg::CAPACITY_DEF,
   parameter int SITES     = scacc_pkg::SITES_DEF,
   parameter int FRAC_BITS = scacc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [scacc_pkg::OP_W-1:0]          req_operation,
   input  logic [scacc_pkg::OCC_W-1:0]         req_occupation,
   input  logic signed [scacc_pkg::COEF_W-1:0] req_coef_re,
   input  logic signed [scacc_pkg::COEF_W-1:0] req_coef_im,
   output logic                                rsp_valid,
   output logic signed [scacc_pkg::COEF_W-1:0] rsp_result_re,
   output logic signed [scacc_pkg::COEF_W-1:0] rsp_result_im,
   output logic                                rsp_key_found,
   output logic                                rsp_table_full,
   output logic [scacc_pkg::CNT_OUT_W-1:0]     rsp_entry_count
);
   import scacc_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int KEY_W = (SITES < OCC_W) ? SITES : OCC_W;

   logic [AW-1:0]            rd_addr, wr_addr;
   mem_wr_type               mem_wr;
   logic [KEY_W-1:0]         wr_key, rd_key;
   logic [2*COEF_W-1:0]      wr_coef, rd_coef;
   logic                     scl_start, scl_done;
   logic signed [COEF_W-1:0] scl_re, scl_im, fac_re, fac_im;

   // sequencer
   scacc_ctrl #(
      .CAPACITY (CAPACITY),
      .KEY_W    (KEY_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_occupation  (req_occupation),
      .req_coef_re     (req_coef_re),
      .req_coef_im     (req_coef_im),
      .rsp_valid       (rsp_valid),
      .rsp_result_re   (rsp_result_re),
      .rsp_result_im   (rsp_result_im),
      .rsp_key_found   (rsp_key_found),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr),
      .mem_wr          (mem_wr),
      .wr_key          (wr_key),
      .wr_coef         (wr_coef),
      .rd_key          (rd_key),
      .rd_coef         (rd_coef),
      .scl_start       (scl_start),
      .scl_done        (scl_done),
      .scl_re          (scl_re),
      .scl_im          (scl_im),
      .fac_re          (fac_re),
      .fac_im          (fac_im)
   );

   // term table
   scacc_store #(
      .CAPACITY (CAPACITY),
      .KEY_W    (KEY_W)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .mem_wr  (mem_wr),
      .wr_key  (wr_key),
      .wr_coef (wr_coef),
      .rd_key  (rd_key),
      .rd_coef (rd_coef)
   );

   // complex scaling unit
   scacc_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (scl_start),
      .coef_in (rd_coef),
      .fac_re  (fac_re),
      .fac_im  (fac_im),
      .done    (scl_done),
      .out_re  (scl_re),
      .out_im  (scl_im)
   );

`ifndef SYNTH
   // an accepted request keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // one response per request, then back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("response not followed by idle");

   // a response only closes a busy period
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a request");

   // a refused append means the key was absent and reports zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |->
         (!rsp_key_found && (rsp_result_re == '0) && (rsp_result_im == '0)))
      else $error("table full response with a coefficient");
`endif

endmodule

FILE: verif/sparse_complex_accumulator_top_tb.sv
// Self-checking testbench for sparse_complex_accumulator_top: drives add/sub/scale/query/erase
// requests and compares every response against an in-bench model of the term table.
// Depends on scacc_pkg and the RTL under src only.
module sparse_complex_accumulator_top_tb;
   import scacc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY  = CAPACITY_DEF;
   localparam int FRAC_BITS = FRAC_BITS_DEF;
   localparam int MAX_SHOWN = 10;
   localparam int TARGET_BEATS = 800;

   localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
   localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

   // codes the block decodes as a query
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   // random phase kinds
   localparam int PH_ACCUM    = 0;
   localparam int PH_SCALE    = 1;
   localparam int PH_FILL     = 2;
   localparam int PH_CLEAR    = 3;
   localparam int PH_NOISE    = 4;
   localparam int PH_PRESSURE = 5;

   typedef struct {
      logic signed [COEF_W-1:0] re;
      logic signed [COEF_W-1:0] im;
      logic                     found;
      logic                     full;
      logic [CNT_OUT_W-1:0]     count;
   } coef_rsp_type;

   function automatic logic signed [COEF_W-1:0] clamp32(logic signed [65:0] v);
      if (v > WIDE_MAX) return COEF_MAX;
      if (v < WIDE_MIN) return COEF_MIN;
      return v[COEF_W-1:0];
   endfunction

   // products: floor shift by the fraction width, then clamp
   function automatic logic signed [COEF_W-1:0] shift_clamp(logic signed [65:0] p);
      return clamp32(p >>> FRAC_BITS);
   endfunction

   // Term table model plus the queue of responses it still owes
   class coef_table_checker;
      logic [OCC_W-1:0]         keys [CAPACITY];
      logic signed [COEF_W-1:0] term_re [CAPACITY];
      logic signed [COEF_W-1:0] term_im [CAPACITY];
      int                       live_terms;
      coef_rsp_type             owed [$];
      int                       error_count;

      function new();
         live_terms = 0;
         error_count = 0;
      endfunction

      function int find_term(logic [OCC_W-1:0] key);
         for (int i = 0; i < live_terms; i++)
            if (keys[i] == key) return i;
         return -1;
      endfunction

      function void coef_of(logic [OCC_W-1:0] key, output logic signed [COEF_W-1:0] re,
                            output logic signed [COEF_W-1:0] im);
         int hit;
         hit = find_term(key);
         re = (hit >= 0) ? term_re[hit] : '0;
         im = (hit >= 0) ? term_im[hit] : '0;
      endfunction

      function void report(string msg);
         error_count++;
         if (error_count <= MAX_SHOWN) $display("%s", msg);
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(logic [OP_W-1:0] op, logic [OCC_W-1:0] key,
                                 logic signed [COEF_W-1:0] cre,
                                 logic signed [COEF_W-1:0] cim);
         int hit;
         int kept;
         logic refused;
         logic signed [65:0] wa, wb, wc, wd;
         coef_rsp_type rsp;
         hit = find_term(key);
         refused = 1'b0;
         wc = cre;
         wd = cim;
         rsp.found = (hit >= 0);
         case (op)
            OP_ADD, OP_SUB: begin
               if (cre != 0 || cim != 0) begin
                  if (hit >= 0) begin
                     wa = term_re[hit];
                     wb = term_im[hit];
                     term_re[hit] = (op == OP_ADD) ? clamp32(wa + wc) : clamp32(wa - wc);
                     term_im[hit] = (op == OP_ADD) ? clamp32(wb + wd) : clamp32(wb - wd);
                  end else if (live_terms >= CAPACITY) begin
                     refused = 1'b1;
                  end else begin
                     keys[live_terms] = key;
                     term_re[live_terms] = (op == OP_ADD) ? cre : clamp32(-wc);
                     term_im[live_terms] = (op == OP_ADD) ? cim : clamp32(-wd);
                     live_terms++;
                  end
               end
            end
            OP_SCALE: begin
               for (int i = 0; i < live_terms; i++) begin
                  wa = term_re[i];
                  wb = term_im[i];
                  term_re[i] = shift_clamp(wa * wc - wb * wd);
                  term_im[i] = shift_clamp(wa * wd + wb * wc);
               end
            end
            OP_ERASE: begin
               // squeeze out all-zero terms, order kept
               kept = 0;
               for (int i = 0; i < live_terms; i++) begin
                  if (term_re[i] != 0 || term_im[i] != 0) begin
                     keys[kept] = keys[i];
                     term_re[kept] = term_re[i];
                     term_im[kept] = term_im[i];
                     kept++;
                  end
               end
               live_terms = kept;
            end
            default: ;
         endcase
         coef_of(key, rsp.re, rsp.im);
         rsp.full = refused;
         rsp.count = live_terms[CNT_OUT_W-1:0];
         owed = {owed, rsp};
      endfunction

      function void check_response(logic signed [COEF_W-1:0] re, logic signed [COEF_W-1:0] im,
                                   logic found, logic full, logic [CNT_OUT_W-1:0] count);
         coef_rsp_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected response: re=%h im=%h found=%b full=%b count=%0d",
                             re, im, found, full, count));
            return;
         end
         want = owed.pop_front();
         if (want.re !== re || want.im !== im || want.found !== found ||
             want.full !== full || want.count !== count)
            report($sformatf({"response mismatch: expected re=%h im=%h found=%b full=%b ",
                              "count=%0d, got re=%h im=%h found=%b full=%b count=%0d"},
                             want.re, want.im, want.found, want.full, want.count,
                             re, im, found, full, count));
      endfunction

      function void flag_leftovers();
         if (owed.size() != 0)
            report($sformatf("%0d expected responses never arrived", owed.size()));
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OP_W-1:0]          req_operation = '0;
   logic [OCC_W-1:0]         req_occupation = '0;
   logic signed [COEF_W-1:0] req_coef_re = '0;
   logic signed [COEF_W-1:0] req_coef_im = '0;
   logic                     rsp_valid;
   logic signed [COEF_W-1:0] rsp_result_re;
   logic signed [COEF_W-1:0] rsp_result_im;
   logic                     rsp_key_found;
   logic                     rsp_table_full;
   logic [CNT_OUT_W-1:0]     rsp_entry_count;

   coef_table_checker table_check = new();
   int beats_sent = 0;
   int burst_left = 0;

   sparse_complex_accumulator_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_occupation  (req_occupation),
      .req_coef_re     (req_coef_re),
      .req_coef_im     (req_coef_im),
      .rsp_valid       (rsp_valid),
      .rsp_result_re   (rsp_result_re),
      .rsp_result_im   (rsp_result_im),
      .rsp_key_found   (rsp_key_found),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response monitor: one beat per strobe, no back-pressure possible
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         table_check.check_response(rsp_result_re, rsp_result_im, rsp_key_found,
                                    rsp_table_full, rsp_entry_count);
   end

   // sender pacing: bursts of back-to-back beats separated by idle gaps
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clock);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 40);
   endtask

   // present one request beat and hold it until the block takes it
   task automatic issue(logic [OP_W-1:0] op, logic [OCC_W-1:0] key,
                        logic signed [COEF_W-1:0] cre, logic signed [COEF_W-1:0] cim);
      start <= 1'b1;
      req_operation <= op;
      req_occupation <= key;
      req_coef_re <= cre;
      req_coef_im <= cim;
      @(posedge clock);
      while (busy) @(posedge clock);
      table_check.note_request(op, key, cre, cim);
      beats_sent++;
      pace();
   endtask

   // hold off until every owed response has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (table_check.owed.size() != 0);
   endtask

   function automatic logic signed [COEF_W-1:0] rand_coef();
      logic signed [COEF_W-1:0] v;
      v = $urandom_range(0, 32'h0008_0000);
      case ($urandom_range(0, 7))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return $urandom_range(0, 1) ? v : -v;
      endcase
   endfunction

   task automatic pick_factor(output logic signed [COEF_W-1:0] fre,
                              output logic signed [COEF_W-1:0] fim);
      fre = $urandom_range(0, 32'h0001_8000);
      fim = $urandom_range(0, 32'h0000_8000);
      case ($urandom_range(0, 6))
         0: begin fre = COEF_ONE; fim = '0; end
         1: begin fre = '0; fim = COEF_ONE; end
         2: begin fre = -COEF_ONE; fim = '0; end
         3: begin fre = $urandom; fim = $urandom; end
         default: begin
            if ($urandom_range(0, 1)) fre = -fre;
            if ($urandom_range(0, 1)) fim = -fim;
         end
      endcase
   endtask

   initial begin
      logic [OCC_W-1:0] pool [6];
      logic [OCC_W-1:0] key;
      logic signed [COEF_W-1:0] cre, cim;
      int phase;
      int n;
      bit first_phase;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, saturation both ways, zero terms, spare codes
      issue(OP_QUERY, 16'hFFFF, '0, '0);
      issue(OP_ADD, 16'hFFFF, COEF_MAX, COEF_MIN);
      issue(OP_ADD, 16'hFFFF, COEF_MAX, COEF_MIN);
      issue(OP_SUB, 16'h0000, COEF_MIN, COEF_MIN);
      issue(OP_SUB, 16'h0000, 32'sd1, -32'sd1);
      issue(OP_ADD, 16'h8001, '0, '0);
      issue(OP_SUB, 16'hFFFF, '0, '0);
      issue(OP_ADD, 16'h5A5A, 32'sh0001_8000, -32'sh0000_8000);
      issue(OP_SUB, 16'h5A5A, 32'sh0001_8000, -32'sh0000_8000);
      issue(OP_ADD, 16'h8001, '0, 32'sd1);
      issue(OP_UNUSED_FIRST, 16'h5A5A, COEF_MAX, COEF_MIN);
      issue(OP_UNUSED_MID, 16'h8001, '0, '0);
      issue(OP_UNUSED_LAST, 16'h1234, '1, '1);
      issue(OP_ERASE, 16'h5A5A, '0, '0);
      // scale: identity, times j, times -1, tiny negative (floor rounding)
      issue(OP_SCALE, 16'hFFFF, COEF_ONE, '0);
      issue(OP_SCALE, 16'h8001, '0, COEF_ONE);
      issue(OP_SCALE, 16'h0000, -COEF_ONE, '0);
      issue(OP_ADD, 16'h00F0, 32'sh0003_0001, -32'sh0002_0003);
      issue(OP_SCALE, 16'h00F0, -32'sd1, 32'sd3);
      drain();
      issue(OP_SCALE, 16'hFFFF, '0, '0);
      issue(OP_ERASE, 16'hFFFF, '0, '0);
      issue(OP_QUERY, 16'hFFFF, '0, '0);

      // random phases; the first one fills the table to force refused appends
      first_phase = 1'b1;
      while (beats_sent < TARGET_BEATS) begin
         case ($urandom_range(0, 19))
            10, 11: phase = PH_SCALE;
            12: phase = PH_FILL;
            13: phase = PH_CLEAR;
            14, 15: phase = PH_NOISE;
            16: phase = PH_PRESSURE;
            default: phase = PH_ACCUM;
         endcase
         if (first_phase) phase = PH_FILL;
         first_phase = 1'b0;
         foreach (pool[i]) begin
            pool[i] = OCC_W'($urandom);
            if ($urandom_range(0, 7) == 0) pool[i] = $urandom_range(0, 1) ? '1 : '0;
         end

         case (phase)
            PH_ACCUM: begin
               n = $urandom_range(10, 30);
               repeat (n) begin
                  key = pool[$urandom_range(0, 5)];
                  case ($urandom_range(0, 15))
                     0, 1, 2, 3, 4, 5: issue(OP_ADD, key, rand_coef(), rand_coef());
                     6, 7, 8: issue(OP_SUB, key, rand_coef(), rand_coef());
                     9: begin
                        // cancel the term so that erase has something to drop
                        table_check.coef_of(key, cre, cim);
                        issue(OP_SUB, key, cre, cim);
                     end
                     10: issue($urandom_range(0, 1) ? OP_ADD : OP_SUB, key, '0, '0);
                     11: issue(OP_QUERY, key, $urandom, $urandom);
                     12: issue(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), key,
                               $urandom, $urandom);
                     13: issue(OP_ADD, 16'($urandom), rand_coef(), rand_coef());
                     14: issue(OP_ERASE, key, $urandom, $urandom);
                     default: issue(OP_ADD, key, $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                                    $urandom_range(0, 1) ? COEF_MAX : COEF_MIN);
                  endcase
               end
            end
            PH_SCALE: begin
               pick_factor(cre, cim);
               issue(OP_SCALE, pool[0], cre, cim);
               if ($urandom_range(0, 1)) issue(OP_ERASE, pool[1], $urandom, $urandom);
            end
            PH_FILL: begin
               while (table_check.live_terms < CAPACITY)
                  issue(OP_ADD, 16'($urandom), rand_coef(), rand_coef());
               // appends of new keys must now be refused
               repeat (3) issue($urandom_range(0, 1) ? OP_ADD : OP_SUB, 16'($urandom),
                                rand_coef() | 32'sd1, rand_coef());
               repeat (4) issue(OP_SUB, table_check.keys[$urandom_range(0, CAPACITY - 1)],
                                rand_coef(), rand_coef());
               pick_factor(cre, cim);
               issue(OP_SCALE, pool[2], cre, cim);
               if ($urandom_range(0, 1)) begin
                  issue(OP_SCALE, pool[3], '0, '0);
                  issue(OP_ERASE, pool[4], $urandom, $urandom);
               end
            end
            PH_CLEAR: begin
               issue(OP_SCALE, pool[0], '0, '0);
               issue(OP_ERASE, pool[1], $urandom, $urandom);
            end
            PH_NOISE: begin
               repeat ($urandom_range(5, 15))
                  issue(3'($urandom), 16'($urandom), $urandom, $urandom);
            end
            default: begin
               drain();
               repeat ($urandom_range(2, 5)) issue(OP_QUERY, pool[$urandom_range(0, 5)],
                                                   $urandom, $urandom);
            end
         endcase
      end

      // wait out the last responses, then a margin for anything stray
      drain();
      repeat (700) @(posedge clock);
      table_check.flag_leftovers();
      if (table_check.error_count == 0)
         $display("sparse_complex_accumulator_top_tb: clean");
      else
         $display("sparse_complex_accumulator_top_tb: errors");
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("sparse_complex_accumulator_top_tb: errors");
      $finish;
   end

endmodule

FILE: filelist.f
src/scacc_pkg.sv
src/scacc_store.sv
src/scacc_scale.sv
src/scacc_ctrl.sv
src/sparse_complex_accumulator_top.sv
verif/sparse_complex_accumulator_top_tb.sv
